// ----- design/smbios_structure_delimiter_macros.svh -----
// ----------------------------------------------------------------------------
// SMBIOS structure delimiter: assertion macros
// Shared concurrent-assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SMBIOS_STRUCTURE_DELIMITER_MACROS_SVH
`define SMBIOS_STRUCTURE_DELIMITER_MACROS_SVH

// Condition that must hold at every edge.
`define SMBD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SMBD_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMBD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/smbd_pkg.sv -----
// ----------------------------------------------------------------------------
// SMBIOS structure delimiter package
// Parse phases, result status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package smbd_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 14;

    localparam int TYPE_BITS   = 8;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 8;

    // smallest legal formatted length (type, length, handle)
    localparam logic [7:0] MIN_FORMATTED_LEN = 8'd4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WANTED_TYPE = 1'b0,
        CFG_REPORT_ALL  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_TYPE      = 3'd0,
        PH_LENGTH    = 3'd1,
        PH_FORMATTED = 3'd2,
        PH_STRINGS   = 3'd3,
        PH_HALTED    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_BADLEN    = 2'd2,
        ST_ENDONLY   = 2'd3
    } status_t;

    typedef struct packed {
        logic    emit;
        status_t status;
        logic    buffer_end;
    } res_ctl_t;

endpackage

// ----- design/smbd_parser.sv -----
// ----------------------------------------------------------------------------
// SMBIOS structure delimiter: byte parser
// Walk state per buffer and the result produced by the current byte.
// ----------------------------------------------------------------------------
`include "smbios_structure_delimiter_macros.svh"

module smbd_parser
    import smbd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [TYPE_BITS-1:0]   table_byte,
    input  logic                   final_byte,
    input  logic [TYPE_BITS-1:0]   wanted_type,
    input  logic                   report_all,
    output res_ctl_t               res_ctl,
    output logic [TYPE_BITS-1:0]   res_type,
    output logic [OFFSET_BITS-1:0] res_offset,
    output logic [OFFSET_BITS-1:0] res_size,
    output logic [INDEX_BITS-1:0]  res_index
);

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [TYPE_BITS-1:0]   type_reg, type_next;
    logic [7:0]             flen_reg, flen_next;
    logic [OFFSET_BITS-1:0] bis_reg, bis_next;
    logic                   pwz_reg, pwz_next;
    logic [INDEX_BITS-1:0]  count_reg, count_next;

    logic                   byte_zero;
    logic                   bad_len;
    logic                   done;
    logic                   sel_after;
    logic                   live_after;
    logic [OFFSET_BITS-1:0] idx;
    logic [OFFSET_BITS-1:0] bis_inc;

    assign byte_zero = (table_byte == '0);
    assign bad_len   = (phase_reg == PH_LENGTH) && (table_byte < MIN_FORMATTED_LEN);
    assign done      = (phase_reg == PH_STRINGS) && byte_zero && pwz_reg;
    assign bis_inc   = bis_reg + 1'b1;
    // type after this byte: the type byte itself loads it
    assign sel_after = report_all ||
                       (((phase_reg == PH_TYPE) ? table_byte : type_reg) == wanted_type);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg + 1'b1;
        start_next = start_reg;
        type_next  = type_reg;
        flen_next  = flen_reg;
        bis_next   = bis_reg;
        pwz_next   = pwz_reg;
        count_next = count_reg;
        case (phase_reg)
            PH_TYPE:
            begin
                type_next  = table_byte;
                start_next = pos_reg;
                bis_next   = OFFSET_BITS'(1);
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                flen_next  = table_byte;
                bis_next   = OFFSET_BITS'(2);
                phase_next = bad_len ? PH_HALTED : PH_FORMATTED;
            end
            PH_FORMATTED:
            begin
                bis_next = bis_inc;
                if (bis_inc == OFFSET_BITS'(flen_reg))
                begin
                    phase_next = PH_STRINGS;
                    pwz_next   = 1'b0;
                end
            end
            PH_STRINGS:
            begin
                if (done)
                begin
                    if (sel_after)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    phase_next = PH_TYPE;
                    pwz_next   = 1'b0;
                end
                else
                begin
                    pwz_next = byte_zero;
                    bis_next = bis_inc;
                end
            end
            default:
            begin
                // halted: ignore bytes until buffer end
            end
        endcase
        if (final_byte)
        begin
            phase_next = PH_TYPE;
            pos_next   = '0;
            start_next = '0;
            type_next  = '0;
            flen_next  = '0;
            bis_next   = '0;
            pwz_next   = 1'b0;
            count_next = '0;
        end
    end

    // result for this byte
    always_comb
    begin
        case (phase_reg)
            PH_TYPE:   idx = '0;
            PH_LENGTH: idx = OFFSET_BITS'(1);
            default:   idx = bis_reg;
        endcase
        // a structure is still open after this byte
        live_after = (phase_reg == PH_TYPE) ||
                     ((phase_reg == PH_LENGTH) && !bad_len) ||
                     (phase_reg == PH_FORMATTED) ||
                     ((phase_reg == PH_STRINGS) && !done);

        res_ctl.buffer_end = final_byte;
        res_index          = count_reg;
        if (bad_len)
        begin
            res_ctl.emit   = 1'b1;
            res_ctl.status = ST_BADLEN;
            res_type       = type_reg;
            res_offset     = start_reg;
            res_size       = OFFSET_BITS'(1);
        end
        else if (done && sel_after)
        begin
            res_ctl.emit   = 1'b1;
            res_ctl.status = ST_COMPLETE;
            res_type       = type_reg;
            res_offset     = start_reg;
            res_size       = idx;
        end
        else if (live_after && sel_after)
        begin
            res_ctl.emit   = final_byte;
            res_ctl.status = ST_TRUNCATED;
            res_type       = (phase_reg == PH_TYPE) ? table_byte : type_reg;
            res_offset     = (phase_reg == PH_TYPE) ? pos_reg : start_reg;
            res_size       = idx;
        end
        else
        begin
            res_ctl.emit   = final_byte;
            res_ctl.status = ST_ENDONLY;
            res_type       = '0;
            res_offset     = '0;
            res_size       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            pos_reg   <= '0;
            start_reg <= '0;
            type_reg  <= '0;
            flen_reg  <= '0;
            bis_reg   <= '0;
            pwz_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            type_reg  <= type_next;
            flen_reg  <= flen_next;
            bis_reg   <= bis_next;
            pwz_reg   <= pwz_next;
            count_reg <= count_next;
        end
    end

    `SMBD_IMPLIES(a_halt_short_len, phase_reg == PH_HALTED, flen_reg < MIN_FORMATTED_LEN,
                  "halted without a short length byte")
    `SMBD_IMPLIES(a_type_no_zero, phase_reg == PH_TYPE, !pwz_reg,
                  "zero flag carried into a new structure")

endmodule

// ----- design/smbios_structure_delimiter.sv -----
// ----------------------------------------------------------------------------
// SMBIOS structure delimiter
// Splits a raw SMBIOS structure table byte stream into structure records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one table byte per beat, with
//   final_byte set on the last byte of a buffer. Output channel
//   (out_valid/out_ready) carries one record per finished structure that
//   passes the type filter, one per bad length byte, and exactly one record
//   on the final byte (buffer_end = 1: completed, truncated, bad length or end only).
//   Config writes (cfg_wr_en/cfg_index/cfg_data) set wanted_type and
//   report_all_types; write them only while the block is idle.
// Timing:
//   One byte per cycle sustained while out_ready stays high. A byte is registered
//   in the input stage at acceptance and parsed from there straight into the
//   output register once that register is free or draining.
// Reset:
//   Parser returns to await the type byte at offset 0, match count 0,
//   wanted_type 0, report_all_types 1, both stages empty.
// Stall:
//   A held record keeps its stage; the input register holds one byte more,
//   then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`include "smbios_structure_delimiter_macros.svh"

module smbios_structure_delimiter
    import smbd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // config write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // byte stream in
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [TYPE_BITS-1:0]     table_byte,
    input  logic                     final_byte,
    // records out
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [TYPE_BITS-1:0]     struct_type,
    output logic [OFFSET_BITS-1:0]   struct_offset,
    output logic [OFFSET_BITS-1:0]   struct_size,
    output logic [INDEX_BITS-1:0]    match_index,
    output logic [1:0]               status,
    output logic                     buffer_end
);

    // config registers
    logic [TYPE_BITS-1:0]   wanted_type_reg;
    logic                   report_all_reg;

    // input stage
    logic                   in_valid_reg;
    logic [TYPE_BITS-1:0]   byte_reg;
    logic                   final_reg;

    // output stage
    logic                   out_valid_reg;
    logic [TYPE_BITS-1:0]   type_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] size_reg;
    logic [INDEX_BITS-1:0]  index_reg;
    status_t                status_reg;
    logic                   end_reg;

    logic                   advance;
    logic                   in_take;
    res_ctl_t               res_ctl;
    logic [TYPE_BITS-1:0]   res_type;
    logic [OFFSET_BITS-1:0] res_offset;
    logic [OFFSET_BITS-1:0] res_size;
    logic [INDEX_BITS-1:0]  res_index;

    // parse the held byte when the output slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg <= '0;
            report_all_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WANTED_TYPE: wanted_type_reg <= cfg_data[TYPE_BITS-1:0];
                CFG_REPORT_ALL:  report_all_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= table_byte;
            final_reg <= final_byte;
        end
    end

    smbd_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .table_byte  (byte_reg),
        .final_byte  (final_reg),
        .wanted_type (wanted_type_reg),
        .report_all  (report_all_reg),
        .res_ctl     (res_ctl),
        .res_type    (res_type),
        .res_offset  (res_offset),
        .res_size    (res_size),
        .res_index   (res_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_ctl.emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_ctl.emit)
        begin
            type_reg   <= res_type;
            offset_reg <= res_offset;
            size_reg   <= res_size;
            index_reg  <= res_index;
            status_reg <= res_ctl.status;
            end_reg    <= res_ctl.buffer_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign struct_type   = type_reg;
    assign struct_offset = offset_reg;
    assign struct_size   = size_reg;
    assign match_index   = index_reg;
    assign status        = status_reg;
    assign buffer_end    = end_reg;

    // final byte always leaves a buffer-end record behind
    `SMBD_NEXT(a_final_gives_end, advance && final_reg, out_valid_reg && end_reg,
               "final byte produced no buffer-end record")
    `SMBD_IMPLIES(a_endonly_zeroed, out_valid_reg && (status_reg == ST_ENDONLY),
                  (type_reg == '0) && (offset_reg == '0) && (size_reg == '0),
                  "end-only record carries structure data")
    `SMBD_IMPLIES(a_mid_status, out_valid_reg && !end_reg,
                  (status_reg == ST_COMPLETE) || (status_reg == ST_BADLEN),
                  "truncated or end-only record before buffer end")

endmodule
